// ===== sv/utf8d_pkg.sv =====
package utf8d_pkg;

  localparam int unsigned CpW = 21;
  localparam logic [CpW-1:0] REPLACEMENT_CP = 21'h00FFFD;

  // results one byte can cause, at most 4
  localparam int unsigned CntW = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           malformed;
    logic           last_of_run;
  } out_item_t;

  // Burst descriptor: count results, all replacements except the final one
  typedef struct packed {
    logic [CntW-1:0] count;
    logic [CpW-1:0]  last_cp;
    logic            last_bad;
  } burst_t;

endpackage

// ===== sv/utf8d_in_reg.sv =====
module utf8d_in_reg
  import utf8d_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_item,
  output logic     in_stall,
  input  logic     take,
  output logic     hold_valid,
  output in_item_t hold_item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     load;

  assign in_stall  = valid_r && !take;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign hold_valid = valid_r;
  assign hold_item  = item_r;

endmodule

// ===== sv/utf8d_decode.sv =====
module utf8d_decode
  import utf8d_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     advance,
  input  in_item_t item,
  output burst_t   dec
);

  logic [2:0]     exp_r, exp_nxt;
  logic [1:0]     held_r, held_nxt;
  logic [CpW-1:0] pv_r, pv_nxt;

  logic [7:0]      b;
  logic            cont;
  logic [1:0]      held_inc;
  logic [CpW-1:0]  pv_inc;
  logic [CntW-1:0] cnt;
  logic [CpW-1:0]  lcp;
  logic            lbad;
  logic            do_fresh;

  assign b    = item.data_byte;
  assign cont = (b[7:6] == 2'b10);

  always_comb begin
    exp_nxt  = exp_r;
    held_nxt = held_r;
    pv_nxt   = pv_r;
    cnt      = '0;
    lcp      = REPLACEMENT_CP;
    lbad     = 1'b1;
    do_fresh = 1'b0;
    held_inc = held_r + 2'd1;
    pv_inc   = {pv_r[CpW-7:0], b[5:0]};

    if (exp_r != 3'd0) begin
      if (cont) begin
        pv_nxt   = pv_inc;
        held_nxt = held_inc;
        if ({1'b0, held_inc} + 3'd1 >= exp_r) begin
          cnt      = CntW'(1);
          lcp      = pv_inc;
          lbad     = 1'b0;
          exp_nxt  = 3'd0;
          held_nxt = 2'd0;
          pv_nxt   = '0;
        end
      end else begin
        // lead plus every held continuation byte become replacements
        cnt      = CntW'(held_r) + CntW'(1);
        do_fresh = 1'b1;
      end
    end else begin
      do_fresh = 1'b1;
    end

    if (do_fresh) begin
      exp_nxt  = 3'd0;
      held_nxt = 2'd0;
      pv_nxt   = '0;
      if (b[7] == 1'b0) begin
        cnt  = cnt + CntW'(1);
        lcp  = CpW'(b);
        lbad = 1'b0;
      end else if (b[7:5] == 3'b110) begin
        exp_nxt = 3'd2;
        pv_nxt  = CpW'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
        exp_nxt = 3'd3;
        pv_nxt  = CpW'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
        exp_nxt = 3'd4;
        pv_nxt  = CpW'(b[2:0]);
      end else begin
        // stray continuation or invalid lead
        cnt  = cnt + CntW'(1);
        lcp  = REPLACEMENT_CP;
        lbad = 1'b1;
      end
    end

    // truncated sequence at end of text
    if (item.end_of_text && (exp_nxt != 3'd0)) begin
      cnt      = cnt + CntW'(held_nxt) + CntW'(1);
      lcp      = REPLACEMENT_CP;
      lbad     = 1'b1;
      exp_nxt  = 3'd0;
      held_nxt = 2'd0;
      pv_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r  <= 3'd0;
      held_r <= 2'd0;
      pv_r   <= '0;
    end else if (advance) begin
      exp_r  <= exp_nxt;
      held_r <= held_nxt;
      pv_r   <= pv_nxt;
    end
  end

  assign dec.count    = cnt;
  assign dec.last_cp  = lcp;
  assign dec.last_bad = lbad;

endmodule

// ===== sv/utf8d_burst.sv =====
module utf8d_burst
  import utf8d_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  burst_t    dec,
  output logic      can_load,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic [CntW-1:0] left_r, left_nxt;
  logic [CpW-1:0]  cp_r;
  logic            bad_r;
  logic            fire;
  logic            final_one;

  assign out_valid = (left_r != '0);
  assign fire      = out_valid && !out_stall;
  assign final_one = (left_r == CntW'(1));
  assign can_load  = !out_valid || (fire && final_one);

  always_comb begin
    left_nxt = left_r;
    if (load) begin
      left_nxt = dec.count;
    end else if (fire) begin
      left_nxt = left_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_r  <= dec.last_cp;
      bad_r <= dec.last_bad;
    end
  end

  assign out_item.code_point  = final_one ? cp_r : REPLACEMENT_CP;
  assign out_item.malformed   = final_one ? bad_r : 1'b1;
  assign out_item.last_of_run = final_one;

endmodule

// ===== sv/utf8_stream_decoder_top.sv =====
// UTF-8 stream decoder. Takes one byte per transaction on in_ (with
// end_of_text on the final byte of a text) and returns decoded code points on
// out_. A byte enters an input register, is decoded against the open-sequence
// state in one pass, and its results land in a result register, which drains
// one transaction per cycle when not stalled. Well-formed text likewise runs
// at one byte per cycle; a byte causing several results holds the input side
// until its final result leaves the result register. A byte that only extends
// a sequence gives no result and still moves at one per cycle. Malformed
// input (stray continuation, lead F8..FF, bad or missing continuation)
// yields 0xFFFD with malformed set, one per buffered byte, and the offending
// byte is then decoded afresh. Overlong forms, surrogates and leads F5..F7
// are not rejected. last_of_run marks the final result caused by each byte.
module utf8_stream_decoder_top
  import utf8d_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic     hold_valid;
  in_item_t hold_item;
  logic     can_load;
  logic     take;
  burst_t   dec;

  // byte moves into decode when the result register is free or emptying now
  assign take = hold_valid && can_load;

  utf8d_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  // sequence state updates only when the byte is taken
  utf8d_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (take),
    .item    (hold_item),
    .dec     (dec)
  );

  // burst of replacements, then the final result of the byte
  utf8d_burst u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .dec       (dec),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== sv/utf8d_checker.sv =====
module utf8d_checker
  import utf8d_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("input transaction changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_repl_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.malformed |-> out_item.code_point == REPLACEMENT_CP)
    else $error("malformed result is not 0xFFFD");

  a_good_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.malformed |-> out_item.last_of_run)
    else $error("decoded value not last of its run");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_item.last_of_run |=> out_valid)
    else $error("run broken before its last result");

endmodule

bind utf8_stream_decoder_top utf8d_checker u_chk (.*);
